### rtl/rsu_pkg.sv
// ----------------------------------------------------------------------------
// rsu_pkg
// Shared types, widths and command codes of the running statistics unit.
// ----------------------------------------------------------------------------
package rsu_pkg;

  localparam int ValueBits  = 16;
  localparam int CountBits  = 24;
  localparam int FracBits   = 16;
  localparam int RecipFrac  = 32;
  localparam int VsumBits   = 40;
  localparam int SqsumBits  = 56;
  localparam int RsumBits   = 56;
  localparam int CfgBits    = 16;
  localparam int StatBits   = 32;

  // shared arithmetic units
  localparam int MulABits   = 56;
  localparam int MulBBits   = 40;
  localparam int ProdBits   = MulABits + MulBBits;
  localparam int DivNumBits = 112;
  localparam int DivDenBits = 56;
  localparam int SqInBits   = 64;
  localparam int RootBits   = SqInBits / 2;
  localparam int IterBits   = 7;
  localparam int DiffBits   = 80;
  localparam int NnBits     = 48;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_COUNT     = 2'd0,
    CFG_MEAN      = 2'd1,
    CFG_HARMONIC  = 2'd2,
    CFG_DEVIATION = 2'd3
  } cfg_index_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MUL_CM,
    OP_MUL_MM,
    OP_MUL_DD,
    OP_MUL_CS,
    OP_DIV_RECIP,
    OP_MUL_VV,
    OP_DIV_RV,
    OP_COMMIT,
    OP_ZERO,
    OP_DIV_MEAN,
    OP_MUL_NS,
    OP_MUL_SS,
    OP_MUL_NN,
    OP_DIV_DEV,
    OP_SQRT_DEV,
    OP_DIV_RMS,
    OP_SQRT_RMS,
    OP_DIV_HARM,
    OP_ZERO_HARM,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    UNIT_NONE,
    UNIT_MUL,
    UNIT_DIV,
    UNIT_SQRT
  } unit_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_ISSUE,
    CTL_WAIT
  } ctl_state_e;

  typedef struct packed {
    logic [ValueBits-1:0] new_value;
    logic                 restart;
  } in_item_t;

  typedef struct packed {
    logic [CountBits-1:0] count_out;
    logic [StatBits-1:0]  mean_q16;
    logic [StatBits-1:0]  deviation_q16;
    logic [StatBits-1:0]  rms_q16;
    logic [StatBits-1:0]  harmonic_q16;
    status_e              status;
  } out_item_t;

  typedef struct packed {
    logic [CfgBits-1:0] init_count;
    logic [CfgBits-1:0] init_mean;
    logic [CfgBits-1:0] init_harmonic;
    logic [CfgBits-1:0] init_deviation;
  } cfg_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic restart;
    logic reject;
    logic count_zero;
    logic rs_zero;
    logic out_busy;
  } dp_status_t;

  function automatic unit_e unit_of(input op_e op);
    unit_e u;
    u = UNIT_NONE;
    if (op inside {OP_MUL_CM, OP_MUL_MM, OP_MUL_DD, OP_MUL_CS, OP_MUL_VV,
                   OP_MUL_NS, OP_MUL_SS, OP_MUL_NN}) begin
      u = UNIT_MUL;
    end else if (op inside {OP_DIV_RECIP, OP_DIV_RV, OP_DIV_MEAN, OP_DIV_DEV,
                            OP_DIV_RMS, OP_DIV_HARM}) begin
      u = UNIT_DIV;
    end else if (op inside {OP_SQRT_DEV, OP_SQRT_RMS}) begin
      u = UNIT_SQRT;
    end
    return u;
  endfunction

endpackage

### rtl/rsu_ctrl.sv
// ----------------------------------------------------------------------------
// rsu_ctrl
// Sequencer: walks one transaction through the datapath command list.
// ----------------------------------------------------------------------------
module rsu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsu_pkg::dp_status_t status,
  output rsu_pkg::dp_cmd_t    cmd
);
  import rsu_pkg::*;

  ctl_state_e state, state_next;
  op_e        cur, cur_next;

  function automatic op_e report_first(input dp_status_t s);
    return s.count_zero ? OP_ZERO : OP_DIV_MEAN;
  endfunction

  function automatic op_e follow(input op_e op, input dp_status_t s);
    op_e n;
    n = OP_OUT;
    case (op)
      OP_CAPTURE:   n = s.restart ? OP_MUL_CM :
                        (s.reject ? report_first(s) : OP_MUL_VV);
      OP_MUL_CM:    n = OP_MUL_MM;
      OP_MUL_MM:    n = OP_MUL_DD;
      OP_MUL_DD:    n = OP_MUL_CS;
      OP_MUL_CS:    n = OP_DIV_RECIP;
      OP_DIV_RECIP: n = s.reject ? report_first(s) : OP_MUL_VV;
      OP_MUL_VV:    n = OP_DIV_RV;
      OP_DIV_RV:    n = OP_COMMIT;
      OP_COMMIT:    n = report_first(s);
      OP_ZERO:      n = OP_OUT;
      OP_DIV_MEAN:  n = OP_MUL_NS;
      OP_MUL_NS:    n = OP_MUL_SS;
      OP_MUL_SS:    n = OP_MUL_NN;
      OP_MUL_NN:    n = OP_DIV_DEV;
      OP_DIV_DEV:   n = OP_SQRT_DEV;
      OP_SQRT_DEV:  n = OP_DIV_RMS;
      OP_DIV_RMS:   n = OP_SQRT_RMS;
      OP_SQRT_RMS:  n = s.rs_zero ? OP_ZERO_HARM : OP_DIV_HARM;
      OP_DIV_HARM:  n = OP_OUT;
      OP_ZERO_HARM: n = OP_OUT;
      default:      n = OP_OUT;
    endcase
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
      cur   <= OP_NONE;
    end else begin
      state <= state_next;
      cur   <= cur_next;
    end
  end

  always_comb begin
    state_next = state;
    cur_next   = cur;
    cmd        = '{start: 1'b0, op: OP_NONE};
    in_stall   = 1'b1;
    case (state)
      CTL_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd        = '{start: 1'b1, op: OP_CAPTURE};
          cur_next   = OP_CAPTURE;
          state_next = CTL_WAIT;
        end
      end
      CTL_ISSUE: begin
        // result load waits for a free output register
        if (!(cur == OP_OUT && status.out_busy)) begin
          cmd        = '{start: 1'b1, op: cur};
          state_next = (cur == OP_OUT) ? CTL_IDLE : CTL_WAIT;
        end
      end
      CTL_WAIT: begin
        if (!status.busy) begin
          cur_next   = follow(cur, status);
          state_next = CTL_ISSUE;
        end
      end
      default: state_next = CTL_IDLE;
    endcase
  end

endmodule

### rtl/rsu_datapath.sv
// ----------------------------------------------------------------------------
// rsu_datapath
// Running sums, work registers, shared shift-add multiplier, restoring
// divider and digit-by-digit square root, and the output register.
// ----------------------------------------------------------------------------
module rsu_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rsu_pkg::cfg_t       cfg,
  input  rsu_pkg::in_item_t   in_data,
  input  rsu_pkg::dp_cmd_t    cmd,
  output rsu_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output rsu_pkg::out_item_t  out_data
);
  import rsu_pkg::*;

  // running state
  logic [CountBits-1:0] cnt;
  logic [VsumBits-1:0]  s1;
  logic [SqsumBits-1:0] s2;
  logic [RsumBits-1:0]  rs;

  // per-transaction work registers
  logic [ValueBits-1:0] wv;
  logic                 wrst;
  logic [CountBits-1:0] wn;
  logic [VsumBits-1:0]  ws1;
  logic [SqsumBits-1:0] ws2;
  logic [RsumBits-1:0]  wrs;
  logic [DiffBits-1:0]  t1;
  logic [NnBits-1:0]    t2;
  logic [SqInBits-1:0]  sx;
  logic [StatBits-1:0]  mean, dev, rms, harm;

  // shared units
  logic [IterBits-1:0]   iter;
  logic                  running;
  op_e                   act;
  logic [MulABits-1:0]   mul_a;
  logic [ProdBits-1:0]   mul_acc;
  logic [DivNumBits-1:0] div_n;
  logic [DivDenBits-1:0] div_r, div_d;
  logic [SqInBits-1:0]   sq_x;
  logic [RootBits+1:0]   sq_rem;
  logic [RootBits-1:0]   sq_root;

  logic [MulABits-1:0]   mul_a_ld;
  logic [MulBBits-1:0]   mul_b_ld;
  logic [DivNumBits-1:0] div_n_ld;
  logic [DivDenBits-1:0] div_d_ld;

  logic [MulABits:0]     mul_sum;
  logic [ProdBits-1:0]   mul_acc_next;
  logic [DivDenBits:0]   div_trial;
  logic                  div_ge;
  logic [DivDenBits-1:0] div_r_next;
  logic [DivNumBits-1:0] div_n_next;
  logic [RootBits+3:0]   sq_trial, sq_cmp;
  logic                  sq_ge;
  logic [RootBits+1:0]   sq_rem_next;
  logic [RootBits-1:0]   sq_root_next;

  logic [VsumBits:0]     s1_sum;
  logic [SqsumBits:0]    s2_sum;
  logic [RsumBits:0]     rs_sum;
  logic [StatBits-1:0]   q_sat32;
  status_e               code;

  // operand selection for the unit a command starts
  always_comb begin
    mul_a_ld = '0;
    mul_b_ld = '0;
    div_n_ld = '0;
    div_d_ld = '0;
    case (cmd.op)
      OP_MUL_CM: begin
        mul_a_ld = MulABits'(cfg.init_count);
        mul_b_ld = MulBBits'(cfg.init_mean);
      end
      OP_MUL_MM: begin
        mul_a_ld = MulABits'(cfg.init_mean);
        mul_b_ld = MulBBits'(cfg.init_mean);
      end
      OP_MUL_DD: begin
        mul_a_ld = MulABits'(cfg.init_deviation);
        mul_b_ld = MulBBits'(cfg.init_deviation);
      end
      OP_MUL_CS: begin
        mul_a_ld = MulABits'(t1[2*CfgBits:0]);
        mul_b_ld = MulBBits'(cfg.init_count);
      end
      OP_MUL_VV: begin
        mul_a_ld = MulABits'(wv);
        mul_b_ld = MulBBits'(wv);
      end
      OP_MUL_NS: begin
        mul_a_ld = MulABits'(s2);
        mul_b_ld = MulBBits'(cnt);
      end
      OP_MUL_SS: begin
        mul_a_ld = MulABits'(s1);
        mul_b_ld = MulBBits'(s1);
      end
      OP_MUL_NN: begin
        mul_a_ld = MulABits'(cnt);
        mul_b_ld = MulBBits'(cnt);
      end
      OP_DIV_RECIP: begin
        div_n_ld = DivNumBits'(cfg.init_count) << RecipFrac;
        div_d_ld = (cfg.init_harmonic == '0) ? DivDenBits'(1)
                                             : DivDenBits'(cfg.init_harmonic);
      end
      OP_DIV_RV: begin
        div_n_ld = DivNumBits'(1) << RecipFrac;
        div_d_ld = DivDenBits'(wv);
      end
      OP_DIV_MEAN: begin
        div_n_ld = DivNumBits'(s1) << FracBits;
        div_d_ld = DivDenBits'(cnt);
      end
      OP_DIV_DEV: begin
        div_n_ld = DivNumBits'(t1) << (2 * FracBits);
        div_d_ld = DivDenBits'(t2);
      end
      OP_DIV_RMS: begin
        div_n_ld = DivNumBits'(s2) << (2 * FracBits);
        div_d_ld = DivDenBits'(cnt);
      end
      OP_DIV_HARM: begin
        div_n_ld = DivNumBits'(cnt) << (RecipFrac + FracBits);
        div_d_ld = DivDenBits'(rs);
      end
      default: ;
    endcase
  end

  // one step of each unit
  always_comb begin
    mul_sum      = {1'b0, mul_acc[ProdBits-1:MulBBits]} +
                   (mul_acc[0] ? {1'b0, mul_a} : '0);
    mul_acc_next = {mul_sum, mul_acc[MulBBits-1:1]};

    div_trial    = {div_r, div_n[DivNumBits-1]};
    div_ge       = div_trial >= {1'b0, div_d};
    div_r_next   = div_ge ? DivDenBits'(div_trial - {1'b0, div_d})
                          : DivDenBits'(div_trial);
    div_n_next   = {div_n[DivNumBits-2:0], div_ge};

    sq_trial     = {sq_rem, sq_x[SqInBits-1:SqInBits-2]};
    sq_cmp       = {2'b00, sq_root, 2'b01};
    sq_ge        = sq_trial >= sq_cmp;
    sq_rem_next  = sq_ge ? (RootBits+2)'(sq_trial - sq_cmp) : (RootBits+2)'(sq_trial);
    sq_root_next = {sq_root[RootBits-2:0], sq_ge};

    q_sat32      = (|div_n_next[DivNumBits-1:StatBits]) ? '1
                                                        : div_n_next[StatBits-1:0];

    s1_sum       = {1'b0, ws1} + (VsumBits+1)'(wv);
    s2_sum       = {1'b0, ws2} + (SqsumBits+1)'(t1[2*ValueBits-1:0]);
    rs_sum       = {1'b0, wrs} + (RsumBits+1)'(t2[RecipFrac:0]);

    if (wv == '0)      code = STATUS_ZERO;
    else if (wn == '1) code = STATUS_FULL;
    else               code = STATUS_OK;
  end

  assign status = '{busy:       running,
                    restart:    wrst,
                    reject:     (code != STATUS_OK),
                    count_zero: (cnt == '0),
                    rs_zero:    (rs == '0),
                    out_busy:   out_valid && out_stall};

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      s1        <= '0;
      s2        <= '0;
      rs        <= '0;
    end else begin
      if (out_valid && !out_stall && !(cmd.start && cmd.op == OP_OUT)) begin
        out_valid <= 1'b0;
      end
      if (cmd.start) begin
        act <= cmd.op;
        case (unit_of(cmd.op))
          UNIT_MUL: begin
            mul_a   <= mul_a_ld;
            mul_acc <= {{MulABits{1'b0}}, mul_b_ld};
            iter    <= IterBits'(MulBBits);
            running <= 1'b1;
          end
          UNIT_DIV: begin
            div_n   <= div_n_ld;
            div_d   <= div_d_ld;
            div_r   <= '0;
            iter    <= IterBits'(DivNumBits);
            running <= 1'b1;
          end
          UNIT_SQRT: begin
            sq_x    <= sx;
            sq_rem  <= '0;
            sq_root <= '0;
            iter    <= IterBits'(RootBits);
            running <= 1'b1;
          end
          default: ;
        endcase
        case (cmd.op)
          OP_CAPTURE: begin
            wv   <= in_data.new_value;
            wrst <= in_data.restart;
            wn   <= in_data.restart ? CountBits'(cfg.init_count) : cnt;
            ws1  <= s1;
            ws2  <= s2;
            wrs  <= rs;
          end
          OP_COMMIT: begin
            cnt <= wn + CountBits'(1);
            s1  <= s1_sum[VsumBits]  ? '1 : s1_sum[VsumBits-1:0];
            s2  <= s2_sum[SqsumBits] ? '1 : s2_sum[SqsumBits-1:0];
            rs  <= rs_sum[RsumBits]  ? '1 : rs_sum[RsumBits-1:0];
          end
          OP_ZERO: begin
            mean <= '0;
            dev  <= '0;
            rms  <= '0;
            harm <= '0;
          end
          OP_ZERO_HARM: harm <= '0;
          OP_OUT: begin
            out_valid <= 1'b1;
            out_data  <= '{count_out:     cnt,
                           mean_q16:      mean,
                           deviation_q16: dev,
                           rms_q16:       rms,
                           harmonic_q16:  harm,
                           status:        code};
          end
          default: ;
        endcase
      end else if (running) begin
        iter <= iter - IterBits'(1);
        case (unit_of(act))
          UNIT_MUL:  mul_acc <= mul_acc_next;
          UNIT_DIV: begin
            div_n <= div_n_next;
            div_r <= div_r_next;
          end
          UNIT_SQRT: begin
            sq_x    <= sq_x << 2;
            sq_rem  <= sq_rem_next;
            sq_root <= sq_root_next;
          end
          default: ;
        endcase
        // last step: write the finished value where the command wants it
        if (iter == IterBits'(1)) begin
          running <= 1'b0;
          case (act)
            OP_MUL_CM: ws1 <= mul_acc_next[VsumBits-1:0];
            OP_MUL_MM: t1  <= DiffBits'(mul_acc_next[2*CfgBits-1:0]);
            OP_MUL_DD: t1  <= t1 + DiffBits'(mul_acc_next[2*CfgBits-1:0]);
            OP_MUL_CS: ws2 <= mul_acc_next[SqsumBits-1:0];
            OP_DIV_RECIP: begin
              wrs <= (|div_n_next[DivNumBits-1:RsumBits]) ? '1
                                                          : div_n_next[RsumBits-1:0];
            end
            OP_MUL_VV: t1 <= DiffBits'(mul_acc_next[2*ValueBits-1:0]);
            OP_DIV_RV: t2 <= NnBits'(div_n_next[RecipFrac:0]);
            OP_DIV_MEAN: mean <= q_sat32;
            OP_MUL_NS: t1 <= mul_acc_next[DiffBits-1:0];
            OP_MUL_SS: begin
              // variance numerator clamped at zero
              t1 <= (t1 >= mul_acc_next[DiffBits-1:0])
                    ? t1 - mul_acc_next[DiffBits-1:0] : '0;
            end
            OP_MUL_NN: t2 <= mul_acc_next[NnBits-1:0];
            OP_DIV_DEV, OP_DIV_RMS: begin
              sx <= (|div_n_next[DivNumBits-1:SqInBits]) ? '1
                                                         : div_n_next[SqInBits-1:0];
            end
            OP_SQRT_DEV: dev <= sq_root_next;
            OP_SQRT_RMS: rms <= sq_root_next;
            OP_DIV_HARM: harm <= q_sat32;
            default: ;
          endcase
        end
      end
    end
  end

endmodule

### rtl/running_statistics_update_unit.sv
// ----------------------------------------------------------------------------
// running_statistics_update_unit
// Running count, mean, deviation, rms and harmonic mean over a sample stream.
//
//   channel   handshake               payload
//   in        in_valid / in_stall     in_data (new_value, restart)
//   out       out_valid / out_stall   out_data (count, stats, status)
//   config    write_enable            reg_index, write_data
//
// One transaction at a time. Most of an accepted sample's time goes to five
// 112-step divisions (six with restart) on the shared one-bit-per-cycle
// divider, plus 40-step multiplies and 32-step square roots.
// A rejected sample skips the update and commit; an empty state skips
// the statistics and reports zeros.
// The output register lets the next sample in while a result waits on stall.
// Reset clears all sums and loads the default configuration.
// ----------------------------------------------------------------------------
module running_statistics_update_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsu_pkg::out_item_t out_data,
  input  logic               write_enable,
  input  logic [1:0]         reg_index,
  input  logic [15:0]        write_data
);
  import rsu_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{init_count:     CfgBits'(1),
               init_mean:      '0,
               init_harmonic:  CfgBits'(1),
               init_deviation: CfgBits'(1)};
    end else if (write_enable) begin
      case (cfg_index_e'(reg_index))
        CFG_COUNT:     cfg.init_count     <= write_data;
        CFG_MEAN:      cfg.init_mean      <= write_data;
        CFG_HARMONIC:  cfg.init_harmonic  <= write_data;
        CFG_DEVIATION: cfg.init_deviation <= write_data;
        default: ;
      endcase
    end
  end

  rsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rsu_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for running_statistics_update_unit. Samples with and
// without restart go in under random idling on both channels; a scoreboard
// keeps its own copy of the running sums and predicts each statistic exactly.
// ----------------------------------------------------------------------------
module tb;
  import rsu_pkg::*;

  localparam int CycleLimit = 4_000_000;

  class stats_scoreboard;
    logic [15:0]  cfg_count, cfg_mean, cfg_harm, cfg_dev;
    logic [63:0]  n_samples, vsum, sqsum, rsum;
    out_item_t    expected_q[$];
    int           errors, seen, restarts, zeros, done;

    function void clear();
      cfg_count = 1; cfg_mean = 0; cfg_harm = 1; cfg_dev = 1;
      n_samples = 0; vsum = 0; sqsum = 0; rsum = 0;
      errors = 0; seen = 0; restarts = 0; zeros = 0; done = 0;
    endfunction

    function void set_reg(cfg_index_e idx, logic [15:0] val);
      case (idx)
        CFG_COUNT:     cfg_count = val;
        CFG_MEAN:      cfg_mean  = val;
        CFG_HARMONIC:  cfg_harm  = val;
        CFG_DEVIATION: cfg_dev   = val;
        default: ;
      endcase
    endfunction

    // floor(num * 2^k / d), saturating at 128 bits
    function logic [127:0] div_sat(logic [127:0] num, int k, logic [63:0] d);
      logic [255:0] q;
      if (d == 0) return '1;
      q = ({128'b0, num} << k) / {192'b0, d};
      if (q[255:128] != 0) return '1;
      return q[127:0];
    endfunction

    function logic [63:0] isqrt(logic [127:0] x);
      logic [63:0]  r, c;
      logic [127:0] sq;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        sq = {64'b0, c} * {64'b0, c};
        if (sq <= x) r = c;
      end
      return r;
    endfunction

    function logic [31:0] clip32(logic [127:0] x);
      return (x > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, int bits);
      logic [64:0] s;
      logic [63:0] lim;
      lim = (64'd1 << bits) - 1;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, lim}) ? lim : s[63:0];
    endfunction

    function out_item_t summarize(status_e st);
      out_item_t    r;
      logic [127:0] a, b, d;
      r = '0;
      r.status = st;
      r.count_out = n_samples[23:0];
      if (n_samples == 0) return r;
      r.mean_q16 = clip32(div_sat({64'b0, vsum}, FracBits, n_samples));
      a = {64'b0, n_samples} * {64'b0, sqsum};
      b = {64'b0, vsum} * {64'b0, vsum};
      d = (a < b) ? 128'd0 : a - b;
      r.deviation_q16 = clip32({64'b0, isqrt(div_sat(div_sat(d, 2 * FracBits, n_samples),
                                                      0, n_samples))});
      r.rms_q16 = clip32({64'b0, isqrt(div_sat({64'b0, sqsum}, 2 * FracBits, n_samples))});
      if (rsum != 0)
        r.harmonic_q16 = clip32(div_sat({64'b0, n_samples}, RecipFrac + FracBits, rsum));
      return r;
    endfunction

    function void note_sample(in_item_t it);
      logic [63:0]  n, s1, s2, rs, h, v;
      logic [127:0] rq;
      n = n_samples; s1 = vsum; s2 = sqsum; rs = rsum;
      v = {48'b0, it.new_value};
      seen++;
      if (it.restart) begin
        restarts++;
        h = (cfg_harm != 0) ? 64'(cfg_harm) : 64'd1;
        n  = 64'(cfg_count);
        s1 = sat_sum(0, n * cfg_mean, VsumBits);
        s2 = sat_sum(0, n * (cfg_mean * cfg_mean + cfg_dev * cfg_dev), SqsumBits);
        rq = div_sat({64'b0, n}, RecipFrac, h);
        rs = sat_sum(0, rq[63:0], RsumBits);
      end
      if (v == 0) begin
        zeros++;
        expected_q.push_back(summarize(STATUS_ZERO));
      end else if (n >= (64'd1 << CountBits) - 1) begin
        expected_q.push_back(summarize(STATUS_FULL));
      end else begin
        n_samples = n + 1;
        vsum  = sat_sum(s1, v, VsumBits);
        sqsum = sat_sum(s2, v * v, SqsumBits);
        rsum  = sat_sum(rs, (64'd1 << RecipFrac) / v, RsumBits);
        expected_q.push_back(summarize(STATUS_OK));
      end
    endfunction

    function void field(string nm, logic [63:0] e, logic [63:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $realtime, nm, e, g);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result transaction: expected none actual count %0d",
                 $realtime, got.count_out);
        return;
      end
      e = expected_q.pop_front();
      done++;
      field("count_out", e.count_out, got.count_out);
      field("mean_q16", e.mean_q16, got.mean_q16);
      field("deviation_q16", e.deviation_q16, got.deviation_q16);
      field("rms_q16", e.rms_q16, got.rms_q16);
      field("harmonic_q16", e.harmonic_q16, got.harmonic_q16);
      field("status", e.status, got.status);
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall;
  in_item_t    in_data = '0;
  logic        out_valid, out_stall = 0;
  out_item_t   out_data;
  logic        write_enable = 0;
  logic [1:0]  reg_index = '0;
  logic [15:0] write_data = '0;
  logic        calm = 0;
  int          cycles = 0;
  stats_scoreboard sb = new();

  running_statistics_update_unit DUT (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .write_enable, .reg_index, .write_data
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("running_statistics_update_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_sample(in_data);
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
  end

  task automatic write_reg(cfg_index_e idx, logic [15:0] val);
    @(posedge clk);
    write_enable <= 1;
    reg_index <= idx;
    write_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    write_enable <= 0;
  endtask

  task automatic load_config(logic [15:0] c, logic [15:0] m, logic [15:0] h, logic [15:0] d);
    write_reg(CFG_COUNT, c);
    write_reg(CFG_MEAN, m);
    write_reg(CFG_HARMONIC, h);
    write_reg(CFG_DEVIATION, d);
  endtask

  // valid stays up across back-to-back transactions
  task automatic send(logic [15:0] v, logic rs);
    if (!calm && $urandom_range(99) < 36) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_data.new_value <= v;
    in_data.restart <= rs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 16'd0;
    if (r < 40) return 16'($urandom_range(1, 255));
    if (r < 55) return 16'hFFFF - 16'($urandom_range(0, 15));
    return 16'($urandom_range(1, 65535));
  endfunction

  initial begin
    sb.clear();
    repeat (4) @(posedge clk);
    rst <= 0;

    // empty state, then defaults
    send(0, 0);
    send(0, 1);
    send(1, 0);
    send(65535, 0);
    send(1, 1);
    send(16'hAAAA, 0);
    send(16'h5555, 0);
    drain();

    // largest seeds, harmonic register zero
    load_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    send(65535, 1);
    send(1, 0);
    send(0, 1);
    send(65535, 0);
    drain();

    // count of zero seeds empty running sums
    load_config(16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
    send(7, 1);
    send(65535, 0);
    send(2, 1);
    drain();

    load_config(16'd1, 16'd0, 16'd1, 16'd0);
    send(3, 1);
    send(3, 0);
    send(1000, 0);
    drain();

    for (int p = 0; p < 5; p++) begin
      load_config(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      calm = (p == 2);
      send(pick_value(), 1);
      for (int i = 0; i < 99; i++) begin
        if (i == 50) begin
          // hold off until the block has answered everything
          in_valid <= 0;
          @(posedge clk);
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        send(pick_value(), $urandom_range(99) < 6);
      end
      drain();
    end
    calm = 0;

    $display("covered %0d samples, %0d with restart, %0d zero, %0d results checked",
             sb.seen, sb.restarts, sb.zeros, sb.done);
    $display("config extremes, zero harmonic and zero count seeds, empty state exercised");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("running_statistics_update_unit verification clean");
    end else begin
      $display("running_statistics_update_unit verification failed");
    end
    $finish;
  end

endmodule
